### hdl/ile_pkg.sv
`timescale 1ns / 1ps
package ile_pkg;
  localparam int Capacity  = 16;
  localparam int DataWidth = 32;
  localparam int IdxW      = 4;
  localparam int CntW      = 5;
  localparam int PosW      = 5;
  localparam int KindW     = 3;
  localparam int StatW     = 2;

  localparam logic [KindW-1:0] KIND_READ     = 3'd0;
  localparam logic [KindW-1:0] KIND_WRITE    = 3'd1;
  localparam logic [KindW-1:0] KIND_FIND     = 3'd2;
  localparam logic [KindW-1:0] KIND_INSERT   = 3'd3;
  localparam logic [KindW-1:0] KIND_APPEND   = 3'd4;
  localparam logic [KindW-1:0] KIND_DELETE   = 3'd5;
  localparam logic [KindW-1:0] KIND_DEL_LAST = 3'd6;

  localparam logic [StatW-1:0] STAT_OK    = 2'd0;
  localparam logic [StatW-1:0] STAT_RANGE = 2'd1;
  localparam logic [StatW-1:0] STAT_FULL  = 2'd2;
  localparam logic [StatW-1:0] STAT_EMPTY = 2'd3;

  typedef enum logic [1:0] {
    OP_NONE, OP_WRITE, OP_INSERT, OP_DELETE
  } shift_op_e;

  // controller -> datapath
  typedef struct packed {
    shift_op_e              op;
    logic [IdxW-1:0]        idx;
    logic signed [DataWidth-1:0] value;
    logic                   load;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic signed [DataWidth-1:0] rd_value;
    logic                   found;
    logic [IdxW-1:0]        match_idx;
  } dp_stat_t;

  typedef struct packed {
    logic [KindW-1:0]       kind;
    logic [PosW-1:0]        position;
    logic signed [DataWidth-1:0] item_value;
  } req_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] read_value;
    logic [IdxW-1:0]        match_index;
    logic                   match_found;
    logic [StatW-1:0]       status;
    logic [CntW-1:0]        element_count;
  } rsp_t;
endpackage

### hdl/ile_if.sv
`timescale 1ns / 1ps
interface ile_req_if;
  logic        valid;
  logic        ready;
  ile_pkg::req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface ile_rsp_if;
  logic        valid;
  logic        ready;
  ile_pkg::rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### hdl/ile_datapath.sv
`timescale 1ns / 1ps
module ile_datapath (
  input  logic              clk_i,
  input  ile_pkg::dp_cmd_t  cmd_i,
  input  logic [ile_pkg::CntW-1:0] count_i,
  output ile_pkg::dp_stat_t stat_o
);
  import ile_pkg::*;

  logic [DataWidth-1:0] cell_q [Capacity];
  logic [DataWidth-1:0] cell_d [Capacity];
  logic [Capacity-1:0]  hit;

  // Cell chain: each cell takes its neighbor or the new value.
  always_comb begin
    for (int i = 0; i < Capacity; i++) begin
      cell_d[i] = cell_q[i];
      unique case (cmd_i.op)
        OP_WRITE: if (i == int'(cmd_i.idx)) cell_d[i] = cmd_i.value;
        OP_INSERT: begin
          if (i == int'(cmd_i.idx)) cell_d[i] = cmd_i.value;
          else if (i > int'(cmd_i.idx) && i > 0) cell_d[i] = cell_q[(i > 0) ? i-1 : 0];
        end
        OP_DELETE:
          if (i >= int'(cmd_i.idx) && i < Capacity-1) cell_d[i] = cell_q[i+1];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int i = 0; i < Capacity; i++) cell_q[i] <= cell_d[i];
    end
  end

  // Parallel compare; only live cells count.
  always_comb begin
    for (int i = 0; i < Capacity; i++)
      hit[i] = (CntW'(i) < count_i) && (cell_q[i] == cmd_i.value);
    stat_o.found     = |hit;
    stat_o.match_idx = '0;
    for (int i = Capacity-1; i >= 0; i--)
      if (hit[i]) stat_o.match_idx = IdxW'(i);
    stat_o.rd_value  = cell_q[cmd_i.idx];
  end
endmodule

### hdl/ile_ctrl.sv
`timescale 1ns / 1ps
module ile_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ile_pkg::req_t     req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ile_pkg::rsp_t     rsp_o,
  output ile_pkg::dp_cmd_t  cmd_o,
  output logic [ile_pkg::CntW-1:0] count_o,
  input  ile_pkg::dp_stat_t stat_i
);
  import ile_pkg::*;

  logic [CntW-1:0] count_q, count_d;
  logic            valid_q;
  rsp_t            rsp_q, rsp_d;
  logic            take;
  logic [CntW-1:0] pos;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign take        = in_valid_i && in_ready_o;
  assign out_valid_o = valid_q;
  assign rsp_o       = rsp_q;
  assign count_o     = count_q;
  assign pos         = req_i.position;

  always_comb begin
    cmd_o.op    = OP_NONE;
    cmd_o.idx   = pos[IdxW-1:0];
    cmd_o.value = req_i.item_value;
    cmd_o.load  = 1'b0;
    count_d     = count_q;
    rsp_d       = '0;
    unique case (req_i.kind)
      KIND_READ:
        if (pos < count_q) rsp_d.read_value = stat_i.rd_value;
        else rsp_d.status = STAT_RANGE;
      KIND_WRITE:
        if (pos < count_q) cmd_o.op = OP_WRITE;
        else rsp_d.status = STAT_RANGE;
      KIND_FIND: begin
        rsp_d.match_found = stat_i.found;
        rsp_d.match_index = stat_i.match_idx;
      end
      KIND_INSERT:
        if (pos > count_q) rsp_d.status = STAT_RANGE;
        else if (count_q >= CntW'(Capacity)) rsp_d.status = STAT_FULL;
        else begin
          cmd_o.op = OP_INSERT;
          count_d  = count_q + 1'b1;
        end
      KIND_APPEND:
        if (count_q >= CntW'(Capacity)) rsp_d.status = STAT_FULL;
        else begin
          cmd_o.op  = OP_WRITE;
          cmd_o.idx = count_q[IdxW-1:0];
          count_d   = count_q + 1'b1;
        end
      KIND_DELETE:
        if (count_q == '0) rsp_d.status = STAT_EMPTY;
        else if (pos >= count_q) rsp_d.status = STAT_RANGE;
        else begin
          cmd_o.op = OP_DELETE;
          rsp_d.read_value = stat_i.rd_value;
          count_d = count_q - 1'b1;
        end
      KIND_DEL_LAST:
        if (count_q == '0) rsp_d.status = STAT_EMPTY;
        else begin
          count_d   = count_q - 1'b1;
          cmd_o.idx = count_d[IdxW-1:0];
          rsp_d.read_value = stat_i.rd_value;
        end
      default: ;
    endcase
    rsp_d.element_count = count_d;
    cmd_o.load = take;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      if (take) count_q <= count_d;
      if (in_ready_o) valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) rsp_q <= rsp_d;
  end
endmodule

### hdl/indexed_list_engine.sv
`timescale 1ns / 1ps
// Ordered list of up to 16 signed 32-bit words held in a shifting register
// chain. Each request item (read, write, find, insert at, append, delete at,
// delete last): the cell chain shifts and the 16-way compare run in the cycle
// the item is accepted, so one item per cycle is sustained while the output
// is drained. The result item sits in an output register; a new request is
// taken whenever that register is empty or is being drained. Refused
// requests (bad position, full, empty) leave the list untouched and report
// a status. Entries are not cleared at reset; only live entries are read.
module indexed_list_engine (
  input logic   clk_i,
  input logic   rst_ni,
  ile_req_if.sink   req,
  ile_rsp_if.source rsp
);
  import ile_pkg::*;

  dp_cmd_t         cmd;
  dp_stat_t        stat;
  logic [CntW-1:0] count;

  // Sequencing, status decode and response register.
  ile_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req.valid),
    .in_ready_o  (req.ready),
    .req_i       (req.payload),
    .out_valid_o (rsp.valid),
    .out_ready_i (rsp.ready),
    .rsp_o       (rsp.payload),
    .cmd_o       (cmd),
    .count_o     (count),
    .stat_i      (stat)
  );

  // Cell chain and parallel search.
  ile_datapath u_dp (
    .clk_i   (clk_i),
    .cmd_i   (cmd),
    .count_i (count),
    .stat_o  (stat)
  );

  // Count never exceeds capacity.
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CntW'(Capacity)) else $error("count overflow");

  // Reported count equals the count register after the item.
  a_count_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req.valid && req.ready) |=> rsp.payload.element_count == count)
    else $error("count mismatch");

  // A found flag only comes with ok status.
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && rsp.payload.match_found) |-> rsp.payload.status == STAT_OK)
    else $error("found with error status");
endmodule
